@@ rtl/core/fully_associative_fifo_cache_unit_assert.svh @@
// Assertion macros for the fully associative FIFO cache unit.
// Included by the checker; no other dependencies.
`ifndef FULLY_ASSOCIATIVE_FIFO_CACHE_UNIT_ASSERT_SVH
`define FULLY_ASSOCIATIVE_FIFO_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FACU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FACU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/facu_pkg.sv @@
// Shared constants, command codes and control types for the FIFO cache unit.
// No dependencies.
`default_nettype none

package facu_pkg;

   localparam int unsigned DEF_NUM_LINES  = 8;
   localparam int unsigned DEF_LINE_BYTES = 16;

   localparam int unsigned CMD_W     = 2;
   localparam int unsigned ADDRESS_W = 32;
   localparam int unsigned DATA_W    = 32;

   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

   // Sequencer to tag store
   typedef struct packed {
      logic start;   // begin a tag scan
      logic alloc;   // claim the line at the FIFO pointer
   } facu_tag_ctl_type;

   // Tag store to sequencer
   typedef struct packed {
      logic done;    // scan finished this cycle
      logic hit;     // a valid line matched
   } facu_tag_sts_type;

   // Index width for a store of n entries, at least one bit.
   function automatic int unsigned idx_w(input int unsigned n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/facu_req_if.sv @@
// Request channel: command, byte address and data word with valid/ready.
// Depends on facu_pkg.
`default_nettype none

interface facu_req_if;
   import facu_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [ADDRESS_W-1:0] address;
   logic [DATA_W-1:0]    write_data;

   modport source (output valid, command, address, write_data, input ready);
   modport sink   (input valid, command, address, write_data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/facu_rsp_if.sv @@
// Response channel: hit flag and read word with valid/ready.
// Depends on facu_pkg.
`default_nettype none

interface facu_rsp_if;
   import facu_pkg::*;

   logic              valid;
   logic              ready;
   logic              hit;
   logic [DATA_W-1:0] read_data;

   modport source (output valid, hit, read_data, input ready);
   modport sink   (input valid, hit, read_data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/facu_tag_store.sv @@
// Tag memory, valid bits and FIFO pointer with a one-compare-per-cycle scan.
// Depends on facu_pkg.
`default_nettype none

module facu_tag_store #(
   parameter int unsigned NUM_LINES = facu_pkg::DEF_NUM_LINES,
   parameter int unsigned TAG_W     = facu_pkg::ADDRESS_W - 4
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  facu_pkg::facu_tag_ctl_type                  ctl,
   input  wire  [TAG_W-1:0]                            tag,
   output facu_pkg::facu_tag_sts_type                  sts,
   output logic [facu_pkg::idx_w(NUM_LINES)-1:0]       line
);
   import facu_pkg::*;

   localparam int unsigned     IDX_W = idx_w(NUM_LINES);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_LINES - 1);

   logic [TAG_W-1:0]     tag_mem [NUM_LINES];
   logic [TAG_W-1:0]     tag_rd_ff;
   logic                 vld_rd_ff;
   logic [NUM_LINES-1:0] valid_ff, valid_in;
   logic                 scan_ff, scan_in;
   logic                 live_ff, live_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]     fifo_ff, fifo_in;
   logic                 match;
   logic                 done;

   // Compare stage works on the tag read issued the cycle before.
   assign match = live_ff && vld_rd_ff && (tag_rd_ff == tag);
   assign done  = live_ff && (match || (cmp_idx_ff == LAST));

   assign sts.done = done;
   assign sts.hit  = match;
   assign line     = match ? cmp_idx_ff : fifo_ff;

   always_comb begin
      scan_in    = scan_ff;
      idx_in     = idx_ff;
      live_in    = 1'b0;
      cmp_idx_in = idx_ff;
      valid_in   = valid_ff;
      fifo_in    = fifo_ff;

      if (ctl.start) begin
         scan_in = 1'b1;
         idx_in  = '0;
      end else if (scan_ff) begin
         if (done) begin
            scan_in = 1'b0;
         end else begin
            live_in = 1'b1;
            if (idx_ff != LAST) begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end

      if (ctl.alloc) begin
         valid_in[fifo_ff] = 1'b1;
         fifo_in = (fifo_ff == LAST) ? '0 : fifo_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= 1'b0;
         live_ff    <= 1'b0;
         idx_ff     <= '0;
         cmp_idx_ff <= '0;
         valid_ff   <= '0;
         fifo_ff    <= '0;
      end else begin
         scan_ff    <= scan_in;
         live_ff    <= live_in;
         idx_ff     <= idx_in;
         cmp_idx_ff <= cmp_idx_in;
         valid_ff   <= valid_in;
         fifo_ff    <= fifo_in;
      end
   end

   // Tags of invalid lines are never looked at, so the memory needs no clear.
   always_ff @(posedge clock) begin
      if (ctl.alloc) begin
         tag_mem[fifo_ff] <= tag;
      end
      tag_rd_ff <= tag_mem[idx_ff];
      vld_rd_ff <= valid_ff[idx_ff];
   end

endmodule

`default_nettype wire

@@ rtl/core/fully_associative_fifo_cache_unit.sv @@
// Fully associative cache, FIFO replacement: top level with sequencer and data memory.
// Depends on facu_pkg, facu_req_if, facu_rsp_if and facu_tag_store.
`default_nettype none

// Fully associative cache of NUM_LINES lines of LINE_BYTES bytes, with FIFO
// replacement. Commands: read (returns hit and the word), write (updates the
// word on a hit only) and fill (writes on a hit, otherwise claims the line at
// the FIFO pointer). Load a whole line with LINE_BYTES/4 fills. Read data is
// zero unless the transfer was a read hit; command 3 does nothing and reports
// no hit. One request is in flight at a time. The tag memory has a single
// read port, so the scan compares one line per cycle in order; then the data
// memory is accessed and the response register is loaded, once it is free.
// A new request is taken while an earlier response waits. After reset the
// data memory is cleared one word a cycle, and no request is taken until
// that pass ends.
module fully_associative_fifo_cache_unit #(
   parameter int unsigned NUM_LINES  = facu_pkg::DEF_NUM_LINES,
   parameter int unsigned LINE_BYTES = facu_pkg::DEF_LINE_BYTES
) (
   input wire          clock,
   input wire          reset,
   facu_req_if.sink    req_bus,
   facu_rsp_if.source  rsp_bus
);
   import facu_pkg::*;

   localparam int unsigned WORDS     = ((LINE_BYTES / 4) > 0) ? (LINE_BYTES / 4) : 1;
   localparam int unsigned DEPTH     = NUM_LINES * WORDS;
   localparam int unsigned WADDR_W   = idx_w(DEPTH);
   localparam int unsigned OFF_W     = idx_w(WORDS);
   localparam int unsigned IDX_W     = idx_w(NUM_LINES);
   localparam int unsigned TAG_SHIFT = $clog2(LINE_BYTES + 1) - 1;
   localparam int unsigned TAG_W     = ADDRESS_W - TAG_SHIFT;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_ACCESS = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [WADDR_W-1:0]  clr_ff, clr_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [DATA_W-1:0]   wdata_ff, wdata_in;
   logic                hit_ff, hit_in;
   logic [WADDR_W-1:0]  waddr_ff, waddr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0]   word_mem [DEPTH];
   logic [DATA_W-1:0]   rd_word_ff;
   logic                mem_we;
   logic [WADDR_W-1:0]  mem_addr;
   logic [DATA_W-1:0]   mem_wdata;

   logic [ADDRESS_W-1:0] off_raw;
   logic [ADDRESS_W-1:0] off_word;
   logic                 cmd_valid;

   facu_tag_ctl_type    tag_ctl;
   facu_tag_sts_type    tag_sts;
   logic [IDX_W-1:0]    tag_line;

   facu_tag_store #(
      .NUM_LINES (NUM_LINES),
      .TAG_W     (TAG_W)
   ) u_tag_store (
      .clock (clock),
      .reset (reset),
      .ctl   (tag_ctl),
      .tag   (tag_ff),
      .sts   (tag_sts),
      .line  (tag_line)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.hit       = rsp_hit_ff;
   assign rsp_bus.read_data = rsp_data_ff;

   // Word offset; it can reach WORDS only when LINE_BYTES is not a power of two.
   assign off_raw  = (req_bus.address & ADDRESS_W'(LINE_BYTES - 1)) >> 2;
   assign off_word = (off_raw >= ADDRESS_W'(WORDS)) ? off_raw - ADDRESS_W'(WORDS) : off_raw;

   assign cmd_valid = cmd_ff inside {CMD_READ, CMD_WRITE, CMD_FILL};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      tag_in       = tag_ff;
      off_in       = off_ff;
      wdata_in     = wdata_ff;
      hit_in       = hit_ff;
      waddr_in     = waddr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      tag_ctl      = '0;
      mem_we       = 1'b0;
      mem_addr     = waddr_ff;
      mem_wdata    = wdata_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == WADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in        = req_bus.command;
               tag_in        = TAG_W'(req_bus.address >> TAG_SHIFT);
               off_in        = OFF_W'(off_word);
               wdata_in      = req_bus.write_data;
               tag_ctl.start = 1'b1;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tag_sts.done) begin
               hit_in   = tag_sts.hit;
               waddr_in = WADDR_W'(tag_line) * WADDR_W'(WORDS) + WADDR_W'(off_ff);
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            mem_we        = ((cmd_ff == CMD_WRITE) && hit_ff) || (cmd_ff == CMD_FILL);
            tag_ctl.alloc = (cmd_ff == CMD_FILL) && !hit_ff;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff && cmd_valid;
               rsp_data_in  = ((cmd_ff == CMD_READ) && hit_ff) ? rd_word_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      tag_ff      <= tag_in;
      off_ff      <= off_in;
      wdata_ff    <= wdata_in;
      hit_ff      <= hit_in;
      waddr_ff    <= waddr_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Data memory: one port, registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[mem_addr] <= mem_wdata;
      end
      rd_word_ff <= word_mem[mem_addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/facu_checker.sv @@
// Port-level checks for the FIFO cache unit, bound to the top level.
// Depends on facu_pkg and fully_associative_fifo_cache_unit_assert.svh.
`default_nettype none

`include "fully_associative_fifo_cache_unit_assert.svh"

module facu_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_ready,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire                        rsp_hit,
   input wire [facu_pkg::DATA_W-1:0] rsp_read_data
);
   import facu_pkg::*;

   `FACU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `FACU_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_hit) && $stable(rsp_read_data), "response payload changed while stalled")
   `FACU_ASSERT_IMPLY(a_data_needs_hit, clock, reset, rsp_valid && (rsp_read_data != '0), rsp_hit, "nonzero read data without a hit")
   `FACU_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request taken while one is in flight")

endmodule

bind fully_associative_fifo_cache_unit facu_checker u_facu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_hit       (rsp_bus.hit),
   .rsp_read_data (rsp_bus.read_data)
);

`default_nettype wire
